@@ design/bdlp_pkg.sv @@
// Package for the button debouncer with long-press detection.
// Holds key codes, register indexes, field widths and the code-mapping functions.
// No dependencies.
package bdlp_pkg;

	localparam int unsigned BUTTONS_W = 5;
	localparam int unsigned DELAY_W   = 10;
	localparam int unsigned COUNT_W   = 4;
	localparam int unsigned KEY_W     = 4;
	localparam int unsigned REG_IDX_W = 2;

	typedef logic [BUTTONS_W-1:0] buttons_t;
	typedef logic [DELAY_W-1:0]   delay_t;
	typedef logic [COUNT_W-1:0]   count_t;
	typedef logic [KEY_W-1:0]     key_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	// key event codes
	localparam key_t EV_NONE        = 4'd0;
	localparam key_t EV_RIGHT       = 4'd1;
	localparam key_t EV_CENTER      = 4'd2;
	localparam key_t EV_LEFT        = 4'd3;
	localparam key_t EV_ENC         = 4'd4;
	localparam key_t EV_MODE        = 4'd5;
	localparam key_t EV_CENTER_HELD = 4'd6;
	localparam key_t EV_ENC_HELD    = 4'd7;
	localparam key_t EV_MODE_HELD   = 4'd8;

	// configuration register indexes
	localparam reg_idx_t REG_BOUNCE_MS  = 2'd0;
	localparam reg_idx_t REG_REPEAT_MS  = 2'd1;
	localparam reg_idx_t REG_LONG_COUNT = 2'd2;

	// register reset values
	localparam delay_t BOUNCE_MS_RST  = 10'd50;
	localparam delay_t REPEAT_MS_RST  = 10'd100;
	localparam count_t LONG_COUNT_RST = 4'd5;

	// lowest pressed button wins: right, center, left, encoder, mode
	function automatic key_t first_pressed(input buttons_t b);
		key_t k;
		k = EV_NONE;
		if (b[0])      k = EV_RIGHT;
		else if (b[1]) k = EV_CENTER;
		else if (b[2]) k = EV_LEFT;
		else if (b[3]) k = EV_ENC;
		else if (b[4]) k = EV_MODE;
		return k;
	endfunction

	// right and left have no long form; long codes map to themselves
	function automatic key_t long_form(input key_t code);
		key_t k;
		case (code)
			EV_CENTER: k = EV_CENTER_HELD;
			EV_ENC:    k = EV_ENC_HELD;
			EV_MODE:   k = EV_MODE_HELD;
			default:   k = code;
		endcase
		return k;
	endfunction

endpackage

@@ design/button_debounce_long_press.sv @@
// Button debouncer with long-press detection: top level.
// A scan goes through one input stage and then one result register, which holds its key_event.
// Throughput: one scan per cycle while the downstream side keeps up; the debounce state advances
// as each registered scan moves into the result register.
// Reset (arst_n low, asynchronous): phase idle, held code and counters zero, registers at
// bounce_ms 50, repeat_ms 100, long_count 5, both pipeline stages empty.
// Depends on bdlp_pkg.
module button_debounce_long_press (
	input  logic       clk,
	input  logic       arst_n,
	// scan stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [4:0] buttons, [5] tick, [7:6] zero
	// key event stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [3:0] key_event, [7:4] zero
	// configuration write port
	input  logic                     wr_en,
	input  bdlp_pkg::reg_idx_t       wr_index,
	input  logic [bdlp_pkg::DELAY_W-1:0] wr_data
);

	// phase codes
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_BOUNCE = 2'd1;
	localparam logic [1:0] PH_HOLD   = 2'd2;

	// configuration registers
	bdlp_pkg::delay_t bounce_ms_q;
	bdlp_pkg::delay_t repeat_ms_q;
	bdlp_pkg::count_t long_count_q;

	// debounce state
	logic [1:0]       phase_q;
	bdlp_pkg::key_t   held_code_q;
	bdlp_pkg::delay_t delay_q;
	bdlp_pkg::count_t hold_periods_q;

	// input stage
	logic               valid_s1;
	bdlp_pkg::buttons_t buttons_s1;
	logic               tick_s1;

	// result register
	logic           out_valid_q;
	bdlp_pkg::key_t key_event_q;

	logic advance;   // the registered scan moves into the result register

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, key_event_q};

	// Write a register whenever wr_en is high; index three decodes to nothing and is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounce_ms_q  <= bdlp_pkg::BOUNCE_MS_RST;
			repeat_ms_q  <= bdlp_pkg::REPEAT_MS_RST;
			long_count_q <= bdlp_pkg::LONG_COUNT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				bdlp_pkg::REG_BOUNCE_MS:  bounce_ms_q  <= wr_data;
				bdlp_pkg::REG_REPEAT_MS:  repeat_ms_q  <= wr_data;
				bdlp_pkg::REG_LONG_COUNT: long_count_q <= wr_data[bdlp_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage: capture a request whenever the stage is free or draining.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			buttons_s1 <= s_tdata[bdlp_pkg::BUTTONS_W-1:0];
			tick_s1    <= s_tdata[bdlp_pkg::BUTTONS_W];
		end
	end

	// Next-state logic for the scan in the input stage.
	logic [1:0]       phase_d;
	bdlp_pkg::key_t   held_code_d;
	bdlp_pkg::delay_t delay_d;
	bdlp_pkg::count_t hold_periods_d;
	bdlp_pkg::key_t   key_event_d;
	logic             expire;
	logic             any_pressed;

	always_comb begin
		phase_d        = phase_q;
		held_code_d    = held_code_q;
		delay_d        = delay_q;
		hold_periods_d = hold_periods_q;
		key_event_d    = bdlp_pkg::EV_NONE;
		any_pressed    = |buttons_s1;

		// Count down on a tick; a count of one or zero expires this scan.
		expire = 1'b0;
		if ((phase_q == PH_BOUNCE || phase_q == PH_HOLD) && tick_s1) begin
			if (delay_q <= bdlp_pkg::delay_t'(1)) begin
				expire  = 1'b1;
				delay_d = '0;
			end else begin
				delay_d = delay_q - bdlp_pkg::delay_t'(1);
			end
		end

		unique case (phase_q)
			PH_BOUNCE: begin
				if (expire) begin
					if (!any_pressed) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d        = PH_HOLD;
						delay_d        = repeat_ms_q;
						hold_periods_d = '0;
					end
				end
			end
			PH_HOLD: begin
				if (expire) begin
					if (!any_pressed) begin
						// release: emit the latched code
						phase_d     = PH_IDLE;
						key_event_d = held_code_q;
					end else begin
						if (hold_periods_q < long_count_q) begin
							hold_periods_d = hold_periods_q + bdlp_pkg::count_t'(1);
						end else begin
							held_code_d = bdlp_pkg::long_form(held_code_q);
						end
						delay_d = repeat_ms_q;
					end
				end
			end
			default: begin
				// idle: latch the first pressed button and load the bounce delay
				phase_d = PH_IDLE;
				if (any_pressed) begin
					held_code_d = bdlp_pkg::first_pressed(buttons_s1);
					delay_d     = bounce_ms_q;
					phase_d     = PH_BOUNCE;
				end
			end
		endcase
	end

	// State and result register advance together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			held_code_q    <= bdlp_pkg::EV_NONE;
			delay_q        <= '0;
			hold_periods_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (advance) begin
				phase_q        <= phase_d;
				held_code_q    <= held_code_d;
				delay_q        <= delay_d;
				hold_periods_q <= hold_periods_d;
				out_valid_q    <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_event_q <= key_event_d;
		end
	end

endmodule
